>>> hw/rtl/dfd_pkg.sv
// ============================================================================
// dfd_pkg: shared definitions for the diagnostic id flood detector
// Field widths, band limits, register indexes, sequencer states and the
// alert record that travels from the sequencer to the output register.
// ============================================================================
package dfd_pkg;

    // Default sizing of the per-id stamp rings.
    localparam int ID_COUNT_DEF   = 256;
    localparam int RING_DEPTH_DEF = 16;
    localparam int STAMP_BITS_DEF = 48;

    // Fixed field widths of the stream payloads.
    localparam int FRAME_ID_W  = 29;
    localparam int STAMP_W     = 48;
    localparam int ALERT_ID_W  = 11;
    localparam int HITS_W      = 5;
    localparam int IN_DATA_W   = 80;
    localparam int OUT_DATA_W  = 64;

    // Configuration registers.
    localparam int WINDOW_W       = 32;
    localparam int MAX_HITS_W     = 4;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_W     = 32;

    localparam logic [WINDOW_W-1:0]   WINDOW_RESET   = 32'd1000000;
    localparam logic [MAX_HITS_W-1:0] MAX_HITS_RESET = 4'd10;

    // Diagnostic id band.
    localparam logic [ALERT_ID_W-1:0] BAND_LOW  = 11'h700;
    localparam logic [ALERT_ID_W-1:0] BAND_HIGH = 11'h7FF;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_WINDOW_LENGTH = 1'b0,
        REG_MAX_HITS      = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_LOAD   = 2'd1,
        ST_CHECK  = 2'd2,
        ST_APPEND = 2'd3
    } seq_state_t;

    typedef struct packed {
        logic                  valid;
        logic [ALERT_ID_W-1:0] id;
        logic [STAMP_W-1:0]    stamp;
        logic [HITS_W-1:0]     hits;
    } alert_t;

endpackage

>>> hw/rtl/diagnostic_id_flood_detector_core.sv
// ============================================================================
// diagnostic_id_flood_detector_core: sliding-window flood detector
// Counts frames per diagnostic CAN id inside a time window and raises an
// alert request when the count exceeds a programmable maximum.
// ============================================================================
// Sequence: a frame in the band reads the ring state of its id (ST_LOAD),
// checks stored stamps for expiry (ST_CHECK, skipped when its ring is empty),
// one stamp-memory read per cycle, then appends its stamp and raises any
// alert (ST_APPEND). A new frame is taken only once the last one is back in
// ST_IDLE; filtered frames never leave ST_IDLE. An alert held at the output
// stalls only a later frame that alerts too. Reset is asynchronous, active
// low; it empties every ring at once via per-id valid bits, no clearing pass.
module diagnostic_id_flood_detector_core #(
    parameter int ID_COUNT   = dfd_pkg::ID_COUNT_DEF,
    parameter int RING_DEPTH = dfd_pkg::RING_DEPTH_DEF,
    parameter int STAMP_BITS = dfd_pkg::STAMP_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dfd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [dfd_pkg::CFG_DATA_W-1:0]      cfg_data,
    // Frame input. tdata: frame_id [28:0], stamp_us [76:29], zero pad [79:77].
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [dfd_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // tuser: frame_error [0].
    input  logic                                s_axis_tuser,
    // Alert output. tdata: alert_id [10:0], alert_stamp_us [58:11],
    // hits_in_window [63:59].
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [dfd_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

    import dfd_pkg::*;

    localparam int SLOT_BITS = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
    localparam int HEAD_BITS = $clog2(RING_DEPTH);
    localparam int CNT_BITS  = $clog2(RING_DEPTH + 1);
    localparam int META_BITS = HEAD_BITS + CNT_BITS;
    localparam int ADDR_BITS = $clog2(ID_COUNT * RING_DEPTH);

    logic [WINDOW_W-1:0]   window_reg;
    logic [MAX_HITS_W-1:0] max_hits_reg;

    logic                  out_valid_reg;
    alert_t                out_data_reg;
    logic                  out_free;
    alert_t                alert;

    logic [SLOT_BITS-1:0]  meta_rd_addr;
    logic [META_BITS-1:0]  meta_rd_data;
    logic                  meta_wr_en;
    logic [SLOT_BITS-1:0]  meta_wr_addr;
    logic [META_BITS-1:0]  meta_wr_data;
    logic [ADDR_BITS-1:0]  stamp_rd_addr;
    logic [STAMP_BITS-1:0] stamp_rd_data;
    logic                  stamp_wr_en;
    logic [ADDR_BITS-1:0]  stamp_wr_addr;
    logic [STAMP_BITS-1:0] stamp_wr_data;

    // Configuration is always taken; the user writes only while idle (not enforced).
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg   <= WINDOW_RESET;
            max_hits_reg <= MAX_HITS_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                REG_WINDOW_LENGTH: window_reg   <= cfg_data[WINDOW_W-1:0];
                REG_MAX_HITS:      max_hits_reg <= cfg_data[MAX_HITS_W-1:0];
                default:           window_reg   <= window_reg;
            endcase
        end
    end

    // The sequencer owns both memories: the per-id ring state (head and
    // count) and the stamp store laid out as ID_COUNT rings of RING_DEPTH.
    dfd_ctrl #(
        .ID_COUNT   (ID_COUNT),
        .RING_DEPTH (RING_DEPTH),
        .STAMP_BITS (STAMP_BITS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .frame_id      (s_axis_tdata[FRAME_ID_W-1:0]),
        .stamp_us      (s_axis_tdata[FRAME_ID_W+STAMP_W-1:FRAME_ID_W]),
        .frame_error   (s_axis_tuser),
        .window_len    (window_reg),
        .max_hits      (max_hits_reg),
        .out_free      (out_free),
        .alert         (alert),
        .meta_rd_addr  (meta_rd_addr),
        .meta_rd_data  (meta_rd_data),
        .meta_wr_en    (meta_wr_en),
        .meta_wr_addr  (meta_wr_addr),
        .meta_wr_data  (meta_wr_data),
        .stamp_rd_addr (stamp_rd_addr),
        .stamp_rd_data (stamp_rd_data),
        .stamp_wr_en   (stamp_wr_en),
        .stamp_wr_addr (stamp_wr_addr),
        .stamp_wr_data (stamp_wr_data)
    );

    dfd_ram #(
        .WIDTH (META_BITS),
        .DEPTH (ID_COUNT)
    ) u_meta_ram (
        .clk     (clk),
        .wr_en   (meta_wr_en),
        .wr_addr (meta_wr_addr),
        .wr_data (meta_wr_data),
        .rd_addr (meta_rd_addr),
        .rd_data (meta_rd_data)
    );

    dfd_ram #(
        .WIDTH (STAMP_BITS),
        .DEPTH (ID_COUNT * RING_DEPTH)
    ) u_stamp_ram (
        .clk     (clk),
        .wr_en   (stamp_wr_en),
        .wr_addr (stamp_wr_addr),
        .wr_data (stamp_wr_data),
        .rd_addr (stamp_rd_addr),
        .rd_data (stamp_rd_data)
    );

    // Output register: holds one alert request, so a stalled consumer only
    // blocks the sequencer when a second alert is ready to leave.
    assign out_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (alert.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (alert.valid)
        begin
            out_data_reg <= alert;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_data_reg.hits, out_data_reg.stamp, out_data_reg.id};

endmodule

>>> hw/rtl/dfd_ram.sv
// ============================================================================
// dfd_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
module dfd_ram #(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/dfd_ctrl.sv
// ============================================================================
// dfd_ctrl: per-frame sequencer of the flood detector
// Filters frames, reads the ring state of the id, pops expired stamps one
// per cycle from the stamp memory, then appends the new stamp and raises any alert.
// ============================================================================
module dfd_ctrl #(
    parameter  int ID_COUNT   = 256,
    parameter  int RING_DEPTH = 16,
    parameter  int STAMP_BITS = 48,
    localparam int SLOT_BITS  = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1,
    localparam int HEAD_BITS  = $clog2(RING_DEPTH),
    localparam int CNT_BITS   = $clog2(RING_DEPTH + 1),
    localparam int META_BITS  = HEAD_BITS + CNT_BITS,
    localparam int ADDR_BITS  = $clog2(ID_COUNT * RING_DEPTH)
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [dfd_pkg::FRAME_ID_W-1:0]       frame_id,
    input  logic [dfd_pkg::STAMP_W-1:0]          stamp_us,
    input  logic                                 frame_error,
    input  logic [dfd_pkg::WINDOW_W-1:0]         window_len,
    input  logic [dfd_pkg::MAX_HITS_W-1:0]       max_hits,
    input  logic                                 out_free,
    output dfd_pkg::alert_t                      alert,
    output logic [SLOT_BITS-1:0]                 meta_rd_addr,
    input  logic [META_BITS-1:0]                 meta_rd_data,
    output logic                                 meta_wr_en,
    output logic [SLOT_BITS-1:0]                 meta_wr_addr,
    output logic [META_BITS-1:0]                 meta_wr_data,
    output logic [ADDR_BITS-1:0]                 stamp_rd_addr,
    input  logic [STAMP_BITS-1:0]                stamp_rd_data,
    output logic                                 stamp_wr_en,
    output logic [ADDR_BITS-1:0]                 stamp_wr_addr,
    output logic [STAMP_BITS-1:0]                stamp_wr_data
);

    import dfd_pkg::*;

    localparam int SUM_BITS = CNT_BITS + 1;

    seq_state_t             state_reg, state_next;
    logic [ID_COUNT-1:0]    valid_reg, valid_next;
    logic [SLOT_BITS-1:0]   slot_reg, slot_next;
    logic [ADDR_BITS-1:0]   base_reg, base_next;
    logic [STAMP_BITS-1:0]  ts_reg, ts_next;
    logic [STAMP_BITS-1:0]  cutoff_reg, cutoff_next;
    logic                   hv_reg, hv_next;
    logic [HEAD_BITS-1:0]   head_reg, head_next;
    logic [CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic [HEAD_BITS-1:0]   ptr_reg, ptr_next;

    logic                   band_hit;
    logic [SLOT_BITS-1:0]   slot_in;
    logic [STAMP_BITS-1:0]  ts_in;
    logic [STAMP_BITS-1:0]  win_ext;
    logic [HEAD_BITS-1:0]   head_rd;
    logic [CNT_BITS-1:0]    cnt_rd;
    logic [SUM_BITS-1:0]    oldest_sum;
    logic [HEAD_BITS-1:0]   oldest;
    logic [HEAD_BITS-1:0]   ptr_inc;
    logic [HEAD_BITS-1:0]   head_inc;
    logic [CNT_BITS-1:0]    cnt_inc;
    logic                   alert_hit;

    // Band check: no frame error, id in 0x700..0x7FF, offset below the id count.
    assign band_hit = !frame_error
                   && (frame_id[FRAME_ID_W-1:ALERT_ID_W] == '0)
                   && (frame_id[ALERT_ID_W-1:8] == BAND_LOW[ALERT_ID_W-1:8])
                   && (9'(frame_id[7:0]) < 9'(ID_COUNT));
    assign slot_in  = SLOT_BITS'(frame_id[7:0]);
    assign ts_in    = STAMP_BITS'(stamp_us);
    assign win_ext  = STAMP_BITS'(window_len);

    // Ring state of an id never written since reset reads as empty.
    assign head_rd = hv_reg ? meta_rd_data[META_BITS-1:CNT_BITS] : '0;
    assign cnt_rd  = hv_reg ? meta_rd_data[CNT_BITS-1:0] : '0;

    always_comb
    begin
        oldest_sum = SUM_BITS'(head_rd) + SUM_BITS'(RING_DEPTH) - SUM_BITS'(cnt_rd);
        if (oldest_sum >= SUM_BITS'(RING_DEPTH))
        begin
            oldest_sum = oldest_sum - SUM_BITS'(RING_DEPTH);
        end
        oldest = HEAD_BITS'(oldest_sum);
    end

    assign ptr_inc  = (ptr_reg == HEAD_BITS'(RING_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
    assign head_inc = (head_reg == HEAD_BITS'(RING_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign cnt_inc  = (cnt_reg == CNT_BITS'(RING_DEPTH)) ? cnt_reg : cnt_reg + 1'b1;
    assign alert_hit = 16'(cnt_inc) > 16'(max_hits);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg   <= slot_next;
        base_reg   <= base_next;
        ts_reg     <= ts_next;
        cutoff_reg <= cutoff_next;
        hv_reg     <= hv_next;
        head_reg   <= head_next;
        cnt_reg    <= cnt_next;
        ptr_reg    <= ptr_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        valid_next    = valid_reg;
        slot_next     = slot_reg;
        base_next     = base_reg;
        ts_next       = ts_reg;
        cutoff_next   = cutoff_reg;
        hv_next       = hv_reg;
        head_next     = head_reg;
        cnt_next      = cnt_reg;
        ptr_next      = ptr_reg;
        in_ready      = 1'b0;
        meta_rd_addr  = slot_in;
        meta_wr_en    = 1'b0;
        meta_wr_addr  = slot_reg;
        meta_wr_data  = {head_inc, cnt_inc};
        stamp_rd_addr = base_reg + ADDR_BITS'(ptr_inc);
        stamp_wr_en   = 1'b0;
        stamp_wr_addr = base_reg + ADDR_BITS'(head_reg);
        stamp_wr_data = ts_reg;
        alert.valid   = 1'b0;
        alert.id      = {BAND_LOW[ALERT_ID_W-1:8], 8'(slot_reg)};
        alert.stamp   = STAMP_W'(ts_reg);
        alert.hits    = HITS_W'(cnt_inc);

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && band_hit)
                begin
                    slot_next   = slot_in;
                    base_next   = ADDR_BITS'(slot_in) * ADDR_BITS'(RING_DEPTH);
                    ts_next     = ts_in;
                    cutoff_next = (ts_in > win_ext) ? ts_in - win_ext : '0;
                    hv_next     = valid_reg[slot_in];
                    state_next  = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                head_next     = head_rd;
                cnt_next      = cnt_rd;
                ptr_next      = oldest;
                stamp_rd_addr = base_reg + ADDR_BITS'(oldest);
                state_next    = (cnt_rd == '0) ? ST_APPEND : ST_CHECK;
            end
            ST_CHECK:
            begin
                if (stamp_rd_data < cutoff_reg)
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    ptr_next   = ptr_inc;
                    state_next = (cnt_reg == CNT_BITS'(1)) ? ST_APPEND : ST_CHECK;
                end
                else
                begin
                    state_next = ST_APPEND;
                end
            end
            ST_APPEND:
            begin
                if (!alert_hit || out_free)
                begin
                    stamp_wr_en          = 1'b1;
                    meta_wr_en           = 1'b1;
                    valid_next[slot_reg] = 1'b1;
                    alert.valid          = alert_hit;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/dfd_chk.sv
// ============================================================================
// dfd_chk: port-level checks of the flood detector
// Watches the stream ports over time; attached to the top level by bind.
// ============================================================================
module dfd_chk (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [dfd_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    import dfd_pkg::*;

    // A pending alert request stays up with unchanged contents until taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("alert request dropped or changed while stalled");

    // Every alert names an id of the diagnostic band.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[ALERT_ID_W-1:8] == BAND_LOW[ALERT_ID_W-1:8])
        else $error("alert id outside the diagnostic band");

    // The new frame is always counted, so an alert never reports zero hits.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:OUT_DATA_W-HITS_W] != '0)
        else $error("alert with zero hits");

    // A frame needs the ring read and append steps before it can alert.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("alert raised too soon after a frame");

endmodule

bind diagnostic_id_flood_detector_core dfd_chk u_dfd_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> tb/diagnostic_id_flood_detector_core_tb.sv
// ============================================================================
// diagnostic_id_flood_detector_core_tb: self-checking bench for the flood core
// Drives CAN frame requests into the detector and keeps its own model of the
// per-id stamp rings. Every alert is checked field by field against the
// alert that the model predicts. A few directed sequences come first, one
// of them with a long output hold-off. After them come random phases under
// several window and limit settings, most with random idling on both streams.
// ============================================================================
module diagnostic_id_flood_detector_core_tb;
    import dfd_pkg::*;

    // The run is ended here if the detector stops making progress.
    localparam int CYCLE_LIMIT = 800000;
    // Drain wait; comfortably more than the time a frame keeps the core busy.
    localparam int DRAIN_CYCLES = 30;

    // One expected alert, in the order of the output fields.
    typedef struct packed {
        logic [ALERT_ID_W-1:0] id;
        logic [STAMP_W-1:0]    stamp;
        logic [HITS_W-1:0]     hits;
    } flood_alert_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [IN_DATA_W-1:0]      s_axis_tdata;
    logic                      s_axis_tuser;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [OUT_DATA_W-1:0]     m_axis_tdata;

    // Model state: register copies and the per-id stamp rings.
    logic [WINDOW_W-1:0]   window_us;
    logic [MAX_HITS_W-1:0] hit_limit;
    logic [STAMP_W-1:0]    stamp_ring [ID_COUNT_DEF][RING_DEPTH_DEF];
    logic [3:0]            ring_wr    [ID_COUNT_DEF];
    logic [4:0]            ring_fill  [ID_COUNT_DEF];

    flood_alert_t alert_q [$];
    int           mismatches;
    int           cycle_count;
    logic [STAMP_W-1:0] now_us;
    bit           tx_gaps;
    bit           rx_stalls;
    int           hold_cycles;

    diagnostic_id_flood_detector_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog: a hung handshake must not run forever.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Idle length for both streams: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Applies one accepted frame to the model rings and queues the alert it
    // raises, if any. Stamps are expired from the oldest end only, and the
    // expiry stops at the first stamp that is not older than the cutoff.
    function automatic void predict_flood(logic [FRAME_ID_W-1:0] id,
                                          logic [STAMP_W-1:0] stamp, logic err);
        logic [STAMP_W-1:0] cutoff;
        logic [3:0]         oldest;
        logic [3:0]         wr;
        int                 fill;
        int                 slot;
        flood_alert_t       hit;
        if (err || id < BAND_LOW || id > BAND_HIGH)
            return;
        slot = int'(id - BAND_LOW);
        if (slot >= ID_COUNT_DEF)
            return;
        wr   = ring_wr[slot];
        fill = ring_fill[slot];
        cutoff = (stamp > window_us) ? stamp - window_us : '0;
        while (fill > 0)
        begin
            oldest = wr - 4'(fill);
            if (stamp_ring[slot][oldest] >= cutoff)
                break;
            fill--;
        end
        // A full ring overwrites its oldest stamp and keeps its count.
        stamp_ring[slot][wr] = stamp;
        ring_wr[slot] = wr + 4'd1;
        if (fill < RING_DEPTH_DEF)
            fill++;
        ring_fill[slot] = 5'(fill);
        if (fill > hit_limit)
        begin
            hit.id    = id[ALERT_ID_W-1:0];
            hit.stamp = stamp;
            hit.hits  = 5'(fill);
            alert_q   = {alert_q, hit};
        end
    endfunction

    // Offers one frame request and returns right after it is accepted. The
    // valid stays high so a back-to-back request follows without a gap.
    task automatic send_frame(input logic [FRAME_ID_W-1:0] id,
                              input logic [STAMP_W-1:0] stamp, input logic err);
        int gap;
        gap = tx_gaps ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  = {3'b000, stamp, id};
        s_axis_tuser  = err;
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_flood(id, stamp, err);
    endtask

    // Stops sending, waits for every predicted alert, then lets any frame that
    // raises no alert finish its expiry loop before the core is touched.
    task automatic drain_alerts();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (alert_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_index = idx;
        cfg_data  = value;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_WINDOW_LENGTH)
            window_us = value;
        else
            hit_limit = value[MAX_HITS_W-1:0];
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic program_regs(input logic [WINDOW_W-1:0] window,
                                input logic [MAX_HITS_W-1:0] limit);
        drain_alerts();
        write_reg(REG_WINDOW_LENGTH, window);
        write_reg(REG_MAX_HITS, {28'd0, limit});
    endtask

    // Error frames and ids outside the band, at the extremes of id and stamp,
    // must leave every ring untouched.
    task automatic test_band_filter();
        send_frame(29'h6FF, 48'hFFFF_FFFF_FFFF, 1'b0);
        send_frame(29'h800, 48'h0, 1'b0);
        send_frame(29'h0, 48'h5555_AAAA_5555, 1'b0);
        send_frame(29'h1FFF_FFFF, 48'hAAAA_5555_AAAA, 1'b0);
        send_frame(29'h7FF, 48'h1234, 1'b1);
        send_frame(29'h700, 48'h0, 1'b1);
    endtask

    // Under the reset settings, seventeen frames of one id within the window
    // fill its ring; the last one overwrites the oldest stamp and the count
    // stays at the ring depth. The stamps end at the largest value.
    task automatic test_full_ring();
        for (int i = 0; i <= RING_DEPTH_DEF; i++)
            send_frame(29'h7FF, 48'hFFFF_FFFF_FFFF - 48'(RING_DEPTH_DEF - i), 1'b0);
    endtask

    // With a zero window only stamps strictly older than the new one expire,
    // and a decreasing stamp stops the expiry at the first newer stamp.
    task automatic test_zero_window();
        program_regs(32'd0, 4'd1);
        send_frame(29'h701, 48'd0, 1'b0);
        send_frame(29'h701, 48'd0, 1'b0);
        send_frame(29'h701, 48'd0, 1'b0);
        send_frame(29'h701, 48'd1, 1'b0);
        send_frame(29'h701, 48'd0, 1'b0);
    endtask

    // Every frame alerts, while the output is held off for a long stretch, so
    // the core must stall its input until the alerts can leave.
    task automatic test_backpressure();
        program_regs(32'hFFFF_FFFF, 4'd0);
        tx_gaps     = 1'b0;
        hold_cycles = 300;
        for (int i = 0; i < 40; i++)
        begin
            now_us += 48'($urandom_range(0, 20));
            send_frame(29'(BAND_LOW) + 29'($urandom_range(0, 3)), now_us, 1'b0);
        end
        tx_gaps = 1'b1;
    endtask

    // One random phase: mostly frames of a few hot ids close in time, so the
    // windows fill up, mixed with stray band ids, slightly older stamps, error
    // frames and ids outside the band.
    task automatic random_phase(input logic [WINDOW_W-1:0] window,
                                input logic [MAX_HITS_W-1:0] limit, input int step_max,
                                input int hot_count, input int frames, input bit idling);
        logic [ALERT_ID_W-1:0] hot [4];
        logic [63:0]           noise;
        logic [FRAME_ID_W-1:0] id;
        logic [STAMP_W-1:0]    stamp;
        int                    sent;
        int                    r;
        program_regs(window, limit);
        tx_gaps   = idling;
        rx_stalls = idling;
        for (int k = 0; k < 4; k++)
            hot[k] = BAND_LOW + 11'($urandom_range(0, ID_COUNT_DEF - 1));
        sent = 0;
        while (sent < frames)
        begin
            r     = $urandom_range(0, 99);
            noise = {$urandom(), $urandom()};
            if (r < 7)
            begin
                id = ($urandom_range(0, 1) != 0) ? 29'(hot[0]) : 29'($urandom());
                send_frame(id, noise[STAMP_W-1:0], 1'b1);
            end
            else if (r < 13)
            begin
                case ($urandom_range(0, 2))
                    0: id = 29'h6FF;
                    1: id = 29'h800;
                    default: id = 29'($urandom());
                endcase
                send_frame(id, noise[STAMP_W-1:0], 1'b0);
            end
            else
            begin
                now_us += 48'($urandom_range(0, step_max));
                stamp = now_us;
                if (r < 18)
                    id = 29'(BAND_LOW) + 29'($urandom_range(0, ID_COUNT_DEF - 1));
                else
                    id = 29'(hot[$urandom_range(0, hot_count - 1)]);
                // Now and then a frame arrives with a slightly older stamp.
                if (r >= 95)
                    stamp = now_us - 48'($urandom_range(0, 4 * step_max + 1));
                send_frame(id, stamp, 1'b0);
                sent++;
            end
        end
    endtask

    task automatic test_random_traffic();
        random_phase(32'd200, 4'd3, 30, 3, 200, 1'b1);
        random_phase(32'hFFFF_FFFF, 4'd15, 500, 2, 160, 1'b1);
        random_phase(32'd1, 4'd0, 2, 4, 150, 1'b0);
        random_phase(32'($urandom_range(20, 5000)), 4'($urandom_range(0, 15)), 40, 4, 200, 1'b1);
        random_phase(32'd0, 4'd1, 1, 2, 120, 1'b1);
        // Stamps near the top of their range.
        now_us = 48'hFFFF_FFFF_0000;
        random_phase(32'd1000, 4'd4, 100, 3, 200, 1'b1);
    endtask

    // Output side: accepts alerts with random stalls, and honors a long
    // hold-off when one is requested.
    initial
    begin : alert_sink
        int stall;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles != 0)
            begin
                stall         = hold_cycles;
                hold_cycles   = 0;
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            else if (rx_stalls && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready = 1'b0;
                repeat (pick_gap()) @(negedge clk);
            end
            else
                m_axis_tready = 1'b1;
        end
    end

    // Each alert request is compared with the oldest predicted alert.
    always @(posedge clk)
    begin : alert_check
        flood_alert_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (alert_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: alert with none expected, actual %h", $time, m_axis_tdata);
            end
            else
            begin
                want = alert_q.pop_front();
                if (m_axis_tdata[10:0] !== want.id)
                begin
                    mismatches++;
                    $display("%0t: alert_id expected %h, actual %h",
                             $time, want.id, m_axis_tdata[10:0]);
                end
                if (m_axis_tdata[58:11] !== want.stamp)
                begin
                    mismatches++;
                    $display("%0t: alert_stamp_us expected %h, actual %h",
                             $time, want.stamp, m_axis_tdata[58:11]);
                end
                if (m_axis_tdata[63:59] !== want.hits)
                begin
                    mismatches++;
                    $display("%0t: hits_in_window expected %0d, actual %0d",
                             $time, want.hits, m_axis_tdata[63:59]);
                end
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_WINDOW_LENGTH;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        mismatches    = 0;
        cycle_count   = 0;
        now_us        = '0;
        tx_gaps       = 1'b1;
        rx_stalls     = 1'b1;
        hold_cycles   = 0;
        window_us     = WINDOW_RESET;
        hit_limit     = MAX_HITS_RESET;
        for (int s = 0; s < ID_COUNT_DEF; s++)
        begin
            ring_wr[s]   = '0;
            ring_fill[s] = '0;
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_band_filter();
        test_full_ring();
        test_zero_window();
        test_backpressure();
        test_random_traffic();

        // Let the last frames finish and catch any stray alert.
        drain_alerts();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
